// File: hdl/idsm_pkg.sv
// Shared types and codes for the IO data startup monitor.
// No dependencies; used by idsm_chan_flags and io_data_startup_monitor.
`timescale 1ns / 1ps

package idsm_pkg;

	// Monitor states
	localparam logic [1:0] ST_IDLE    = 2'd0;
	localparam logic [1:0] ST_STARTUP = 2'd1;
	localparam logic [1:0] ST_WDATA   = 2'd2;
	localparam logic [1:0] ST_DATA    = 2'd3;

	// Request kinds
	localparam logic [1:0] REQ_MGR      = 2'd0;
	localparam logic [1:0] REQ_CONS_RUN = 2'd1;
	localparam logic [1:0] REQ_NEW_DATA = 2'd2;
	localparam logic [1:0] REQ_POLL     = 2'd3;

	// Manager events
	localparam logic [1:0] EV_ABORT     = 2'd0;
	localparam logic [1:0] EV_STARTUP   = 2'd1;
	localparam logic [1:0] EV_PRM_END   = 2'd2;
	localparam logic [1:0] EV_DATA      = 2'd3;

	// Configuration register indexes
	localparam logic [1:0] CFG_NUM_CH   = 2'd0;
	localparam logic [1:0] CFG_OUT_MASK = 2'd1;
	localparam logic [1:0] CFG_ADV      = 2'd2;

	// Channels beyond this never count as output type
	localparam int MASK_W = 8;

	// Commands from the sequencer to the channel flag bank
	typedef struct packed {
		logic       clr;   // clear flags of output channels in use
		logic       wr;    // store one flag
		logic [7:0] idx;   // channel addressed by the store
		logic       val;   // value stored
	} chan_ctl_t;

	// Status from the flag bank
	typedef struct packed {
		logic in_range;    // idx names a channel in use
		logic all_started; // every output channel in use has started
	} chan_stat_t;

endpackage

// File: hdl/idsm_chan_flags.sv
// Per-channel started flags with the all-started reduction.
// Depends on idsm_pkg (chan_ctl_t, chan_stat_t, MASK_W).
`timescale 1ns / 1ps

module idsm_chan_flags #(
	parameter int MAX_CHANNELS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [7:0]            n_use,
	input  logic [7:0]            out_mask,
	input  idsm_pkg::chan_ctl_t   ctl,
	input  logic                  commit,
	output idsm_pkg::chan_stat_t  stat
);

	localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

	logic [MAX_CHANNELS-1:0] started_q;
	logic [MAX_CHANNELS-1:0] watch;   // in use and of output type
	logic [IDX_W-1:0]        wr_sel;

	assign wr_sel = ctl.idx[IDX_W-1:0];
	assign stat.in_range = (ctl.idx < n_use);
	assign stat.all_started = &(~watch | started_q);

	genvar gi;
	generate
		for (gi = 0; gi < MAX_CHANNELS; gi++) begin : g_ch
			localparam logic [7:0] CH = 8'(gi);

			// Channel is watched when in use and flagged as output
			if (gi < idsm_pkg::MASK_W) begin : g_mask
				assign watch[gi] = (CH < n_use) && out_mask[gi];
			end else begin : g_nomask
				assign watch[gi] = 1'b0;
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					started_q[gi] <= 1'b0;
				end else if (commit) begin
					if (ctl.clr && watch[gi]) begin
						started_q[gi] <= 1'b0;
					end else if (ctl.wr && stat.in_range && (wr_sel == IDX_W'(gi))) begin
						started_q[gi] <= ctl.val;
					end
				end
			end
		end
	endgenerate

endmodule

// File: hdl/io_data_startup_monitor.sv
// Top level of the IO data startup monitor: input stage, state sequencer,
// result register. Depends on idsm_pkg and idsm_chan_flags.
`timescale 1ns / 1ps

// One event word enters per cycle while the output is drained. The word is
// held in an input register; the state machine and the channel flag
// reduction decide between that register and the result register, where
// its result word is registered, and the state is updated as the word
// moves on. A result waiting at the output holds the word in the input
// register. An empty input register still takes one more word, and after
// that the input stalls until the result is taken. Sustained throughput is
// one word per cycle while the output is drained. The started flags are
// flip-flops cleared by reset.
module io_data_startup_monitor #(
	parameter int MAX_CHANNELS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	// event stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // event_code[1:0], channel_index[9:2], flag_value[10], zero
	input  logic [1:0]  s_tuser,  // req_type[1:0]
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // monitor_state[1:0], status[2], abort_request[3],
	                              // info_valid[4], all_started[5], zero[7:6]
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	// Configuration registers
	logic [3:0] num_ch_q;
	logic [7:0] out_mask_q;
	logic       adv_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_ch_q   <= '0;
			out_mask_q <= '0;
			adv_q      <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				idsm_pkg::CFG_NUM_CH:   num_ch_q   <= cfg_data[3:0];
				idsm_pkg::CFG_OUT_MASK: out_mask_q <= cfg_data;
				idsm_pkg::CFG_ADV:      adv_q      <= cfg_data[0];
				default:                ;
			endcase
		end
	end

	// Channels in use, limited to the flag bank size
	localparam logic [7:0] MAX_CH8 = 8'(MAX_CHANNELS);
	logic [7:0] n_use;
	assign n_use = ({4'b0, num_ch_q} > MAX_CH8) ? MAX_CH8 : {4'b0, num_ch_q};

	// Input register
	logic       valid_s1;
	logic [1:0] req_s1;
	logic [1:0] ev_s1;
	logic [7:0] ch_s1;
	logic       flag_s1;
	logic       adv_s1;

	logic       out_valid_q;
	logic [7:0] out_data_q;

	assign adv_s1   = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_s1  <= s_tuser;
			ev_s1   <= s_tdata[1:0];
			ch_s1   <= s_tdata[9:2];
			flag_s1 <= s_tdata[10];
		end
	end

	// Sequencer state
	logic [1:0] state_q;
	logic       poll_q;

	logic [1:0]           state_d;
	logic                 poll_d;
	logic                 status_d;
	logic                 abort_d;
	logic                 info_d;
	logic                 possible_d;
	idsm_pkg::chan_ctl_t  ctl;
	idsm_pkg::chan_stat_t cstat;

	idsm_chan_flags #(
		.MAX_CHANNELS(MAX_CHANNELS)
	) u_flags (
		.clk      (clk),
		.arst_n   (arst_n),
		.n_use    (n_use),
		.out_mask (out_mask_q),
		.ctl      (ctl),
		.commit   (adv_s1),
		.stat     (cstat)
	);

	// Next state and result for the word in the input register
	always_comb begin
		state_d    = state_q;
		poll_d     = poll_q;
		status_d   = 1'b0;
		abort_d    = 1'b0;
		info_d     = 1'b0;
		possible_d = 1'b0;
		ctl.clr    = 1'b0;
		ctl.wr     = 1'b0;
		ctl.idx    = ch_s1;
		ctl.val    = flag_s1;
		case (req_s1)
			idsm_pkg::REQ_MGR: begin
				case (state_q)
					idsm_pkg::ST_IDLE: begin
						if (ev_s1 == idsm_pkg::EV_ABORT) begin
							poll_d = 1'b0;
						end else if (ev_s1 == idsm_pkg::EV_STARTUP) begin
							ctl.clr = 1'b1;
							poll_d  = 1'b0;
							state_d = idsm_pkg::ST_STARTUP;
						end
					end
					idsm_pkg::ST_STARTUP: begin
						if (ev_s1 == idsm_pkg::EV_ABORT) begin
							poll_d  = 1'b0;
							state_d = idsm_pkg::ST_IDLE;
						end else if (ev_s1 == idsm_pkg::EV_STARTUP) begin
							ctl.clr = 1'b1;
							state_d = idsm_pkg::ST_WDATA;
						end else if (ev_s1 == idsm_pkg::EV_PRM_END) begin
							poll_d  = 1'b1;
							state_d = idsm_pkg::ST_WDATA;
						end
					end
					idsm_pkg::ST_WDATA: begin
						if (ev_s1 == idsm_pkg::EV_ABORT) begin
							poll_d  = 1'b0;
							state_d = idsm_pkg::ST_IDLE;
						end else if (ev_s1 == idsm_pkg::EV_DATA) begin
							poll_d  = 1'b0;
							state_d = idsm_pkg::ST_DATA;
						end
					end
					default: begin
						if (ev_s1 == idsm_pkg::EV_ABORT) begin
							poll_d  = 1'b0;
							state_d = idsm_pkg::ST_IDLE;
						end
					end
				endcase
			end
			idsm_pkg::REQ_CONS_RUN: begin
				// stop asks for abort in legacy startup or in data
				if (state_q == idsm_pkg::ST_STARTUP) begin
					abort_d = !adv_q && !flag_s1;
				end else if (state_q == idsm_pkg::ST_WDATA) begin
					ctl.wr   = 1'b1;
					status_d = !cstat.in_range;
				end else if (state_q == idsm_pkg::ST_DATA) begin
					abort_d = !flag_s1;
				end
			end
			idsm_pkg::REQ_NEW_DATA: begin
				if (state_q == idsm_pkg::ST_WDATA) begin
					ctl.wr   = 1'b1;
					status_d = !cstat.in_range;
				end
			end
			default: begin
				// poll tick
				if (state_q == idsm_pkg::ST_WDATA && poll_q) begin
					info_d     = 1'b1;
					possible_d = cstat.all_started;
				end else begin
					poll_d = 1'b0;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= idsm_pkg::ST_IDLE;
			poll_q  <= 1'b0;
		end else if (adv_s1) begin
			state_q <= state_d;
			poll_q  <= poll_d;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_data_q <= {2'b00, possible_d, info_d, abort_d, status_d, state_d};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// Checks
	a_report_in_wdata: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_data_q[4] |-> out_data_q[1:0] == idsm_pkg::ST_WDATA)
		else $error("poll report outside wait-data");
	a_possible_needs_info: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_data_q[5] |-> out_data_q[4])
		else $error("all_started without info_valid");
	a_abort_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_data_q[3] |->
		(out_data_q[1:0] == idsm_pkg::ST_STARTUP || out_data_q[1:0] == idsm_pkg::ST_DATA))
		else $error("abort request in wrong state");
	a_poll_only_wdata: assert property (@(posedge clk) disable iff (!arst_n)
		poll_q |-> state_q == idsm_pkg::ST_WDATA)
		else $error("polling running outside wait-data");

endmodule
